// ===== design/dedup_event_mailbox_assert.svh =====
// Assertion macros for the mailbox RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef DEDUP_EVENT_MAILBOX_ASSERT_SVH
`define DEDUP_EVENT_MAILBOX_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define DEM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define DEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dem_pkg.sv =====
// Shared types and codes for the deduplicating event mailbox.
// No dependencies; imported by dem_ctrl, dem_dp and dedup_event_mailbox.
package dem_pkg;

   localparam int ID_W  = 60;
   localparam int SEQ_W = 32;
   localparam int CNT_W = 32;

   // Request operation codes
   localparam logic [1:0] OP_PUSH     = 2'd0;
   localparam logic [1:0] OP_DRAIN    = 2'd1;
   localparam logic [1:0] OP_FINALIZE = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_PUSH    = 2'd0;
   localparam logic [1:0] KIND_DRAINED = 2'd1;
   localparam logic [1:0] KIND_EMPTY   = 2'd2;
   localparam logic [1:0] KIND_FINAL   = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SEND
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic push;
      logic finalize;
      logic drain;
      logic rd_en;
      logic send;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic count_zero;
      logic drain_last;
   } status_type;

endpackage

// ===== design/dem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/dem_ctrl.sv =====
// Mailbox controller: request/response handshake and drain sequencing.
// Depends on dem_pkg.
module dem_ctrl
   import dem_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_operation,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // State and output-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready    = out_free;
            cmd.push     = req_valid && out_free && (req_operation == OP_PUSH);
            cmd.finalize = req_valid && out_free && (req_operation == OP_FINALIZE);
            cmd.drain    = req_valid && out_free && (req_operation == OP_DRAIN);
            if (cmd.drain && !status.count_zero) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               cmd.send = 1'b1;
               state_in = status.drain_last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Output valid: set on any new result, cleared when taken.
      // A drain of a non-empty store answers only through its sends.
      if (cmd.push || cmd.finalize || (cmd.drain && status.count_zero) || cmd.send) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/dem_dp.sv =====
// Mailbox datapath: identity compare lanes, counters, event RAM, result register.
// Depends on dem_pkg, dem_ram and the assertion macro header.
`include "dedup_event_mailbox_assert.svh"
module dem_dp
   import dem_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [3:0]         req_event_reason,
   input  logic [31:0]        req_request_ident,
   input  logic [7:0]         req_stage_number,
   input  logic [15:0]        req_generation_number,
   input  cmd_type            cmd,
   output status_type         status,
   output logic [1:0]         rsp_result_kind,
   output logic               rsp_accepted,
   output logic               rsp_duplicate,
   output logic               rsp_full_drop,
   output logic [SEQ_W-1:0]   rsp_sequence_res,
   output logic [3:0]         rsp_out_reason,
   output logic [31:0]        rsp_out_request,
   output logic [7:0]         rsp_out_stage,
   output logic [15:0]        rsp_out_generation,
   output logic               rsp_last_of_run,
   output logic               rsp_work_pending,
   output logic [CNT_W-1:0]   rsp_deliveries
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = ID_W + SEQ_W;

   // Pending identities in flops so every entry is compared at once
   logic [ID_W-1:0]  ident_ff [QUEUE_DEPTH];
   logic [CW-1:0]    count_ff, count_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [CNT_W-1:0] deliv_ff, deliv_in;
   logic             fin_ff, fin_in;
   logic [CW-1:0]    len_ff, len_in;
   logic [IW-1:0]    idx_ff, idx_in;

   // Result register
   logic [1:0]       kind_ff, kind_in;
   logic             acc_ff, acc_in;
   logic             dup_ff, dup_in;
   logic             full_ff, full_in;
   logic [SEQ_W-1:0] rseq_ff, rseq_in;
   logic [ID_W-1:0]  rid_ff, rid_in;
   logic             last_ff, last_in;
   logic             work_ff, work_in;
   logic [CNT_W-1:0] rdel_ff, rdel_in;

   logic [ID_W-1:0]        req_id;
   logic [QUEUE_DEPTH-1:0] match;
   logic                   dup;
   logic                   full;
   logic                   store;
   logic                   drain_last;
   logic [EW-1:0]          ram_q;

   assign req_id = {req_event_reason, req_request_ident, req_stage_number,
                    req_generation_number};

   // Compare lanes: only entries below the fill count take part
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_lane
      assign match[i] = (ident_ff[i] == req_id) && (CW'(i) < count_ff);

      always_ff @(posedge clock) begin
         if (store && (count_ff[IW-1:0] == IW'(i))) begin
            ident_ff[i] <= req_id;
         end
      end
   end

   assign dup   = |match;
   assign full  = (count_ff == CW'(QUEUE_DEPTH));
   assign store = cmd.push && !dup && !full;

   assign drain_last        = ((CW'(idx_ff) + CW'(1)) == len_ff);
   assign status.count_zero = (count_ff == '0);
   assign status.drain_last = drain_last;

   // Identity and sequence kept together for the drain walk
   dem_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_event_ram (
      .clock   (clock),
      .wr_en   (store),
      .wr_addr (count_ff[IW-1:0]),
      .wr_data ({req_id, seq_ff}),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_q)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         seq_ff   <= '0;
         deliv_ff <= '0;
         fin_ff   <= 1'b0;
         len_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         seq_ff   <= seq_in;
         deliv_ff <= deliv_in;
         fin_ff   <= fin_in;
         len_ff   <= len_in;
         idx_ff   <= idx_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      acc_ff  <= acc_in;
      dup_ff  <= dup_in;
      full_ff <= full_in;
      rseq_ff <= rseq_in;
      rid_ff  <= rid_in;
      last_ff <= last_in;
      work_ff <= work_in;
      rdel_ff <= rdel_in;
   end

   // Next state and result for each command
   always_comb begin
      count_in = count_ff;
      seq_in   = seq_ff;
      deliv_in = deliv_ff;
      fin_in   = fin_ff;
      len_in   = len_ff;
      idx_in   = idx_ff;
      kind_in  = kind_ff;
      acc_in   = acc_ff;
      dup_in   = dup_ff;
      full_in  = full_ff;
      rseq_in  = rseq_ff;
      rid_in   = rid_ff;
      last_in  = last_ff;
      work_in  = work_ff;
      rdel_in  = rdel_ff;

      if (cmd.push) begin
         kind_in = KIND_PUSH;
         acc_in  = store;
         dup_in  = dup;
         full_in = full && !dup;
         rseq_in = store ? seq_ff : '0;
         rid_in  = '0;
         last_in = 1'b1;
         work_in = store || (count_ff != '0) || fin_ff;
         rdel_in = deliv_ff;
         if (store) begin
            count_in = count_ff + CW'(1);
            seq_in   = seq_ff + SEQ_W'(1);
         end
      end

      if (cmd.finalize) begin
         fin_in  = 1'b1;
         kind_in = KIND_FINAL;
         acc_in  = 1'b0;
         dup_in  = 1'b0;
         full_in = 1'b0;
         rseq_in = '0;
         rid_in  = '0;
         last_in = 1'b1;
         work_in = 1'b1;
         rdel_in = deliv_ff;
      end

      // Drain start: empty store answers at once, otherwise latch the run length
      if (cmd.drain) begin
         fin_in = 1'b0;
         if (count_ff == '0) begin
            kind_in = KIND_EMPTY;
            acc_in  = 1'b0;
            dup_in  = 1'b0;
            full_in = 1'b0;
            rseq_in = '0;
            rid_in  = '0;
            last_in = 1'b1;
            work_in = 1'b0;
            rdel_in = deliv_ff;
         end else begin
            len_in   = count_ff;
            idx_in   = '0;
            count_in = '0;
            deliv_in = deliv_ff + CNT_W'(1);
         end
      end

      // One drained event per send
      if (cmd.send) begin
         kind_in = KIND_DRAINED;
         acc_in  = 1'b0;
         dup_in  = 1'b0;
         full_in = 1'b0;
         rseq_in = ram_q[SEQ_W-1:0];
         rid_in  = ram_q[EW-1:SEQ_W];
         last_in = drain_last;
         work_in = 1'b0;
         rdel_in = deliv_ff;
         idx_in  = idx_ff + IW'(1);
      end
   end

   assign rsp_result_kind    = kind_ff;
   assign rsp_accepted       = acc_ff;
   assign rsp_duplicate      = dup_ff;
   assign rsp_full_drop      = full_ff;
   assign rsp_sequence_res   = rseq_ff;
   assign rsp_out_reason     = rid_ff[59:56];
   assign rsp_out_request    = rid_ff[55:24];
   assign rsp_out_stage      = rid_ff[23:16];
   assign rsp_out_generation = rid_ff[15:0];
   assign rsp_last_of_run    = last_ff;
   assign rsp_work_pending   = work_ff;
   assign rsp_deliveries     = rdel_ff;

   // Checks
   `DEM_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      count_ff <= CW'(QUEUE_DEPTH), "fill count exceeds store depth")
   `DEM_ASSERT_NEXT(a_no_store_when_full, clock, reset, cmd.push && full && !dup,
      count_ff == $past(count_ff), "push into full store changed fill count")
   `DEM_ASSERT_NOW(a_send_in_range, clock, reset, cmd.send,
      CW'(idx_ff) < len_ff, "drain read past end of run")
   `DEM_ASSERT_NEXT(a_drain_clears, clock, reset, cmd.drain,
      count_ff == '0 && !fin_ff, "drain left events or finalize pending")

endmodule

// ===== design/dedup_event_mailbox.sv =====
// Push, finalize and empty drain: result registered in the cycle after the request;
// one request per cycle while the result register drains.
// Drain of N events: each event is read from the event RAM, then loaded into the
// result register once the output is free; no request is taken meanwhile.
// Synchronous reset clears counters, flags and sequencing; stores are not cleared.
module dedup_event_mailbox
   import dem_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [3:0]         req_event_reason,
   input  logic [31:0]        req_request_ident,
   input  logic [7:0]         req_stage_number,
   input  logic [15:0]        req_generation_number,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_result_kind,
   output logic               rsp_accepted,
   output logic               rsp_duplicate,
   output logic               rsp_full_drop,
   output logic [31:0]        rsp_sequence_res,
   output logic [3:0]         rsp_out_reason,
   output logic [31:0]        rsp_out_request,
   output logic [7:0]         rsp_out_stage,
   output logic [15:0]        rsp_out_generation,
   output logic               rsp_last_of_run,
   output logic               rsp_work_pending,
   output logic [31:0]        rsp_deliveries
);

   cmd_type    cmd;
   status_type status;

   dem_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   dem_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .req_event_reason      (req_event_reason),
      .req_request_ident     (req_request_ident),
      .req_stage_number      (req_stage_number),
      .req_generation_number (req_generation_number),
      .cmd                   (cmd),
      .status                (status),
      .rsp_result_kind       (rsp_result_kind),
      .rsp_accepted          (rsp_accepted),
      .rsp_duplicate         (rsp_duplicate),
      .rsp_full_drop         (rsp_full_drop),
      .rsp_sequence_res      (rsp_sequence_res),
      .rsp_out_reason        (rsp_out_reason),
      .rsp_out_request       (rsp_out_request),
      .rsp_out_stage         (rsp_out_stage),
      .rsp_out_generation    (rsp_out_generation),
      .rsp_last_of_run       (rsp_last_of_run),
      .rsp_work_pending      (rsp_work_pending),
      .rsp_deliveries        (rsp_deliveries)
   );

endmodule
